FILE: rtl/core/ftc_pkg.sv
// ----------------------------------------------------------------------------
// ftc_pkg
// Shared constants, types and helpers of the force/torque calibration block.
// ----------------------------------------------------------------------------
`default_nettype none

package ftc_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 32;
	localparam int FRAC_BITS   = 16;

	localparam int CHANS      = 6;
	localparam int AXES       = 6;
	localparam int COEF_DEPTH = AXES * CHANS;
	localparam int COEF_AW    = $clog2(COEF_DEPTH);
	localparam int IDX_W      = 3;
	localparam int OUT_W      = 32;
	localparam int DIFF_W     = SAMPLE_BITS + 1;
	localparam int PROD_W     = DIFF_W + COEF_BITS;
	localparam int SUM_W      = PROD_W + $clog2(CHANS);
	localparam int ACC_W      = (SUM_W > OUT_W) ? SUM_W : OUT_W + 1;
	localparam int HI_W       = ACC_W - OUT_W + 1;

	localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(CHANS - 1);
	localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(AXES - 1);

	typedef enum logic [1:0] {
		OP_CONVERT = 2'd0,
		OP_CAPTURE = 2'd1,
		OP_WRITE   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef logic signed [DIFF_W-1:0]    diff_t;
	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic signed [OUT_W-1:0]     axis_val_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} tap_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] row;
		axis_val_t        value;
		logic             clip;
	} axis_t;

	function automatic logic [COEF_AW-1:0] coef_addr(input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col);
		return COEF_AW'(row) * COEF_AW'(CHANS) + COEF_AW'(col);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/force_torque_calibration.sv
// ----------------------------------------------------------------------------
// force_torque_calibration
// Six-channel strain-gauge to force/torque conversion with bias removal and a
// 6x6 signed fixed-point calibration matrix held in a coefficient memory.
// ----------------------------------------------------------------------------
// A convert beat reads 36 coefficients through the single memory read port and
// shared multiplier, then drains the pipeline and loads the output register.
// One convert is processed at a time, so the next beat is accepted only after
// the result of a convert is loaded into the output register, which waits while
// the previous result still sits there.
// Capture and write beats complete in the cycle they are accepted.
// Reset clears the bias registers and marks every coefficient as zero.
`default_nettype none

module force_torque_calibration (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] channel_0,
	input  wire logic [15:0] channel_1,
	input  wire logic [15:0] channel_2,
	input  wire logic [15:0] channel_3,
	input  wire logic [15:0] channel_4,
	input  wire logic [15:0] channel_5,
	input  wire logic [2:0]  coef_row,
	input  wire logic [2:0]  coef_col,
	input  wire logic [31:0] coef_value,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [31:0]      force_x,
	output logic [31:0]      force_y,
	output logic [31:0]      force_z,
	output logic [31:0]      torque_x,
	output logic [31:0]      torque_y,
	output logic [31:0]      torque_z,
	output logic             clipped
);

	typedef logic signed [ftc_pkg::SAMPLE_BITS-1:0] sample_t;

	ftc_pkg::state_t            state_q;
	ftc_pkg::state_t            state_d;
	logic                       accept;
	logic                       is_convert;
	logic                       is_capture;
	logic                       is_write;
	logic                       issue;
	logic                       issue_last;
	logic                       out_load;
	logic                       wr_ok;
	sample_t                    ch [ftc_pkg::CHANS];
	sample_t                    bias_q [ftc_pkg::CHANS];
	ftc_pkg::diff_t             diff_q [ftc_pkg::CHANS];
	logic [ftc_pkg::IDX_W-1:0]  rd_row_q;
	logic [ftc_pkg::IDX_W-1:0]  rd_col_q;
	ftc_pkg::tap_t              tap_s1;
	ftc_pkg::coef_t             coef_s1;
	ftc_pkg::axis_t             axis;
	ftc_pkg::axis_val_t         res_q [ftc_pkg::AXES];
	logic                       clip_q;
	ftc_pkg::axis_val_t         out_q [ftc_pkg::AXES];
	logic                       out_clip_q;
	logic                       result_valid_q;

	assign ch[0] = channel_0[ftc_pkg::SAMPLE_BITS-1:0];
	assign ch[1] = channel_1[ftc_pkg::SAMPLE_BITS-1:0];
	assign ch[2] = channel_2[ftc_pkg::SAMPLE_BITS-1:0];
	assign ch[3] = channel_3[ftc_pkg::SAMPLE_BITS-1:0];
	assign ch[4] = channel_4[ftc_pkg::SAMPLE_BITS-1:0];
	assign ch[5] = channel_5[ftc_pkg::SAMPLE_BITS-1:0];

	always_comb begin
		is_convert = 1'b0;
		is_capture = 1'b0;
		is_write   = 1'b0;
		unique case (operation)
			ftc_pkg::OP_CONVERT: is_convert = 1'b1;
			ftc_pkg::OP_CAPTURE: is_capture = 1'b1;
			ftc_pkg::OP_WRITE:   is_write   = 1'b1;
			default: begin
			end
		endcase
	end

	assign accept     = item_valid && item_ready;
	assign issue_last = (rd_row_q == ftc_pkg::LAST_ROW) && (rd_col_q == ftc_pkg::LAST_COL);
	assign wr_ok      = (coef_row <= ftc_pkg::LAST_ROW) && (coef_col <= ftc_pkg::LAST_COL);

	always_comb begin
		item_ready = 1'b0;
		issue      = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ftc_pkg::ST_IDLE:  item_ready = 1'b1;
			ftc_pkg::ST_ISSUE: issue      = 1'b1;
			ftc_pkg::ST_DRAIN: begin
			end
			ftc_pkg::ST_DONE:  out_load   = !result_valid_q || result_ready;
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ftc_pkg::ST_IDLE: begin
				if (accept && is_convert) begin
					state_d = ftc_pkg::ST_ISSUE;
				end
			end
			ftc_pkg::ST_ISSUE: begin
				if (issue_last) begin
					state_d = ftc_pkg::ST_DRAIN;
				end
			end
			ftc_pkg::ST_DRAIN: begin
				if (axis.vld && (axis.row == ftc_pkg::LAST_ROW)) begin
					state_d = ftc_pkg::ST_DONE;
				end
			end
			ftc_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = ftc_pkg::ST_IDLE;
				end
			end
			default: state_d = ftc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ftc_pkg::ST_IDLE;
			rd_row_q       <= '0;
			rd_col_q       <= '0;
			tap_s1         <= '0;
			result_valid_q <= 1'b0;
			clip_q         <= 1'b0;
			for (int i = 0; i < ftc_pkg::CHANS; i++) begin
				bias_q[i] <= '0;
			end
		end else begin
			state_q    <= state_d;
			tap_s1.vld <= issue;
			tap_s1.row <= rd_row_q;
			tap_s1.col <= rd_col_q;
			if (accept && is_convert) begin
				rd_row_q <= '0;
				rd_col_q <= '0;
				clip_q   <= 1'b0;
			end else if (issue) begin
				if (rd_col_q == ftc_pkg::LAST_COL) begin
					rd_col_q <= '0;
					rd_row_q <= rd_row_q + 1'b1;
				end else begin
					rd_col_q <= rd_col_q + 1'b1;
				end
			end
			if (axis.vld && axis.clip) begin
				clip_q <= 1'b1;
			end
			if (accept && is_capture) begin
				for (int i = 0; i < ftc_pkg::CHANS; i++) begin
					bias_q[i] <= ch[i];
				end
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_convert) begin
			for (int i = 0; i < ftc_pkg::CHANS; i++) begin
				diff_q[i] <= ftc_pkg::DIFF_W'(ch[i]) - ftc_pkg::DIFF_W'(bias_q[i]);
			end
		end
		if (axis.vld) begin
			res_q[axis.row] <= axis.value;
		end
		if (out_load) begin
			for (int i = 0; i < ftc_pkg::AXES; i++) begin
				out_q[i] <= res_q[i];
			end
			out_clip_q <= clip_q;
		end
	end

	ftc_coef_mem u_coef_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && is_write && wr_ok),
		.wr_addr (ftc_pkg::coef_addr(coef_row, coef_col)),
		.wr_data (coef_value[ftc_pkg::COEF_BITS-1:0]),
		.rd_en   (issue),
		.rd_addr (ftc_pkg::coef_addr(rd_row_q, rd_col_q)),
		.rd_data (coef_s1)
	);

	ftc_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.tap_s1  (tap_s1),
		.coef_s1 (coef_s1),
		.diff    (diff_q),
		.axis    (axis)
	);

	assign result_valid = result_valid_q;
	assign force_x      = out_q[0];
	assign force_y      = out_q[1];
	assign force_z      = out_q[2];
	assign torque_x     = out_q[3];
	assign torque_y     = out_q[4];
	assign torque_z     = out_q[5];
	assign clipped      = out_clip_q;

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(axis.vld || tap_s1.vld) |-> !item_ready)
		else $error("input accepted while a conversion is in flight");

	a_last_axis_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(axis.vld && (axis.row == ftc_pkg::LAST_ROW)) |=> (state_q == ftc_pkg::ST_DONE))
		else $error("last axis result did not complete the conversion");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ftc_pkg::ST_DONE))
		else $error("result raised outside of the done state");

endmodule

`default_nettype wire

FILE: rtl/core/ftc_coef_mem.sv
// ----------------------------------------------------------------------------
// ftc_coef_mem
// Calibration coefficient memory with one write port and one registered read
// port. Per-entry valid bits make entries read as zero until first written.
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_coef_mem (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [ftc_pkg::COEF_AW-1:0]  wr_addr,
	input  wire ftc_pkg::coef_t               wr_data,
	input  wire logic                         rd_en,
	input  wire logic [ftc_pkg::COEF_AW-1:0]  rd_addr,
	output ftc_pkg::coef_t                    rd_data
);

	ftc_pkg::coef_t                    mem [ftc_pkg::COEF_DEPTH];
	logic [ftc_pkg::COEF_DEPTH-1:0]    vld_q;
	ftc_pkg::coef_t                    rd_data_q;
	logic                              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/ftc_mac.sv
// ----------------------------------------------------------------------------
// ftc_mac
// Shared multiply-accumulate pipeline: selects the channel difference, forms
// the product, sums one row, then floors, shifts and saturates the axis.
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_mac (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ftc_pkg::tap_t   tap_s1,
	input  wire ftc_pkg::coef_t  coef_s1,
	input  wire ftc_pkg::diff_t  diff [ftc_pkg::CHANS],
	output ftc_pkg::axis_t       axis
);

	logic signed [ftc_pkg::PROD_W-1:0] prod_s2;
	ftc_pkg::tap_t                     tap_s2;
	logic signed [ftc_pkg::ACC_W-1:0]  acc_q;
	logic signed [ftc_pkg::ACC_W-1:0]  acc_sum;
	logic signed [ftc_pkg::ACC_W-1:0]  fin_s3;
	logic                              fin_vld_s3;
	logic [ftc_pkg::IDX_W-1:0]         fin_row_s3;
	logic signed [ftc_pkg::ACC_W-1:0]  shifted;
	logic [ftc_pkg::HI_W-1:0]          hi;
	logic                              ovf;
	ftc_pkg::axis_val_t                sat_val;
	ftc_pkg::axis_t                    axis_q;
	ftc_pkg::diff_t                    diff_sel;

	assign diff_sel = diff[tap_s1.col];

	always_ff @(posedge clk) begin
		prod_s2 <= diff_sel * coef_s1;
		if (tap_s2.vld) begin
			acc_q <= acc_sum;
		end
		fin_s3          <= acc_sum;
		fin_row_s3      <= tap_s2.row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s2     <= '0;
			fin_vld_s3 <= 1'b0;
			axis_q     <= '0;
		end else begin
			tap_s2       <= tap_s1;
			fin_vld_s3   <= tap_s2.vld && (tap_s2.col == ftc_pkg::LAST_COL);
			axis_q.vld   <= fin_vld_s3;
			axis_q.row   <= fin_row_s3;
			axis_q.value <= sat_val;
			axis_q.clip  <= ovf;
		end
	end

	always_comb begin
		acc_sum = ((tap_s2.col == '0) ? '0 : acc_q) + ftc_pkg::ACC_W'(prod_s2);
		shifted = fin_s3 >>> ftc_pkg::FRAC_BITS;
		hi      = shifted[ftc_pkg::ACC_W-1:ftc_pkg::OUT_W-1];
		ovf     = !((&hi) || (~|hi));
		if (!ovf) begin
			sat_val = shifted[ftc_pkg::OUT_W-1:0];
		end else if (shifted[ftc_pkg::ACC_W-1]) begin
			sat_val = {1'b1, {(ftc_pkg::OUT_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(ftc_pkg::OUT_W-1){1'b1}}};
		end
	end

	assign axis = axis_q;

endmodule

`default_nettype wire
